// ===== rtl/cnm_pkg.sv =====
// ----------------------------------------------------------------------------
// cnm_pkg
// Shared types, constants and the calendar table for the next-match search.
// ----------------------------------------------------------------------------
`default_nettype none

package cnm_pkg;

  localparam int MINUTES_PER_HOUR = 60;
  localparam int HOURS_PER_DAY    = 24;
  localparam int DAYS_PER_WEEK    = 7;
  localparam int MONTHS_PER_YEAR  = 12;

  localparam int MIN_W  = 6;
  localparam int HOUR_W = 5;
  localparam int DAY_W  = 5;
  localparam int MON_W  = 4;
  localparam int WD_W   = 3;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 60;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MINUTE_MASK   = 3'd0,
    REG_HOUR_MASK     = 3'd1,
    REG_DAY_MASK      = 3'd2,
    REG_MONTH_MASK    = 3'd3,
    REG_WEEKDAY_MASK  = 3'd4,
    REG_FIRST_WEEKDAY = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [59:0] minute_mask;
    logic [23:0] hour_mask;
    logic [30:0] day_mask;
    logic [11:0] month_mask;
    logic [6:0]  weekday_mask;
    logic [2:0]  first_weekday;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WALK,
    ST_DONE
  } state_t;

  // Zero-based index of the last day of a month, non-leap year.
  function automatic logic [DAY_W-1:0] month_last_day(input logic [MON_W-1:0] mo);
    logic [DAY_W-1:0] d;
    case (mo)
      4'd1:                   d = 5'd27;
      4'd3, 4'd5, 4'd8, 4'd10: d = 5'd29;
      default:                d = 5'd30;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/cnm_if.sv =====
// ----------------------------------------------------------------------------
// cnm_if
// Valid/ready channels of the next-match search: query, result, register write.
// ----------------------------------------------------------------------------
`default_nettype none

interface cnm_in_if;
  logic       valid;
  logic       ready;
  logic [5:0] now_minute;
  logic [4:0] now_hour;
  logic [4:0] now_day;
  logic [3:0] now_month;

  modport source (output valid, now_minute, now_hour, now_day, now_month, input ready);
  modport sink   (input valid, now_minute, now_hour, now_day, now_month, output ready);
endinterface

interface cnm_out_if;
  logic       valid;
  logic       ready;
  logic       found;
  logic [5:0] next_minute;
  logic [4:0] next_hour;
  logic [4:0] next_day;
  logic [3:0] next_month;
  logic [2:0] next_weekday;

  modport source (output valid, found, next_minute, next_hour, next_day, next_month,
                  next_weekday, input ready);
  modport sink   (input valid, found, next_minute, next_hour, next_day, next_month,
                  next_weekday, output ready);
endinterface

interface cnm_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [59:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/cron_next_match_search.sv =====
// ----------------------------------------------------------------------------
// cron_next_match_search
// Finds the next time in the year allowed by five cron-style bitmap masks.
// ----------------------------------------------------------------------------
// One query at a time. After an item is accepted, a one-bit-per-cycle scan
// over the minute and hour masks finds the first allowed minute and hour and
// the next ones after the current time; an empty minute or hour mask ends
// the search there with a miss. Else a walker visits the dates of the year
// from January 1 one per cycle and stops at the first allowed date that
// yields a later time, or with a miss after December 31. The done state hands
// the result on once the output register is free; in_ch is not ready till then.
// Registers may be written at any time the block holds no query.
`default_nettype none

module cron_next_match_search (
  input  wire logic  clk,
  input  wire logic  rst_n,
  cnm_in_if.sink     in_ch,
  cnm_out_if.source  out_ch,
  cnm_cfg_if.sink    cfg_ch
);

  localparam logic [5:0] LAST_SCAN  = 6'(cnm_pkg::MINUTES_PER_HOUR - 1);
  localparam logic [5:0] HOURS      = 6'(cnm_pkg::HOURS_PER_DAY);
  localparam logic [3:0] LAST_MONTH = 4'(cnm_pkg::MONTHS_PER_YEAR - 1);
  localparam logic [2:0] LAST_WD    = 3'(cnm_pkg::DAYS_PER_WEEK - 1);

  cnm_pkg::cfg_t cfg;

  cnm_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  cnm_pkg::state_t state_r, state_nxt;

  logic [5:0] now_min_r, now_min_nxt;
  logic [4:0] now_hr_r,  now_hr_nxt;
  logic [4:0] now_day_r, now_day_nxt;
  logic [3:0] now_mon_r, now_mon_nxt;

  logic [5:0] idx_r, idx_nxt;
  logic       fm_vld_r, fm_vld_nxt, lm_vld_r, lm_vld_nxt;
  logic       fh_vld_r, fh_vld_nxt, lh_vld_r, lh_vld_nxt;
  logic       hr_ok_r, hr_ok_nxt;
  logic [5:0] fm_r, fm_nxt, lm_r, lm_nxt;
  logic [4:0] lh_r, lh_nxt;
  logic [4:0] fh_r, fh_nxt;

  logic [3:0] mo_r, mo_nxt;
  logic [4:0] d_r, d_nxt;
  logic [2:0] wd_r, wd_nxt;

  logic       res_found_r, res_found_nxt;
  logic [5:0] res_min_r, res_min_nxt;
  logic [4:0] res_hr_r, res_hr_nxt;
  logic [4:0] res_day_r, res_day_nxt;
  logic [3:0] res_mon_r, res_mon_nxt;
  logic [2:0] res_wd_r, res_wd_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic       out_found_r, out_found_nxt;
  logic [5:0] out_min_r, out_min_nxt;
  logic [4:0] out_hr_r, out_hr_nxt;
  logic [4:0] out_day_r, out_day_nxt;
  logic [3:0] out_mon_r, out_mon_nxt;
  logic [2:0] out_wd_r, out_wd_nxt;

  logic       mbit, hbit;
  logic       today_vld, use_later_min;
  logic [5:0] today_min;
  logic [4:0] today_hr;
  logic       allowed, is_now, is_later, last_day;

  assign in_ch.ready = (state_r == cnm_pkg::ST_IDLE);

  assign out_ch.valid        = out_valid_r;
  assign out_ch.found        = out_found_r;
  assign out_ch.next_minute  = out_min_r;
  assign out_ch.next_hour    = out_hr_r;
  assign out_ch.next_day     = out_day_r;
  assign out_ch.next_month   = out_mon_r;
  assign out_ch.next_weekday = out_wd_r;

  // Shared bit scan: one minute bit and one hour bit per cycle.
  assign mbit = cfg.minute_mask[idx_r];
  assign hbit = (idx_r < HOURS) && cfg.hour_mask[idx_r[4:0]];

  // Candidate time if the walk lands on the current date.
  assign use_later_min = hr_ok_r && lm_vld_r;
  assign today_vld     = use_later_min || lh_vld_r;
  assign today_min     = use_later_min ? lm_r : fm_r;
  assign today_hr      = use_later_min ? now_hr_r : lh_r;

  assign allowed  = cfg.day_mask[d_r] && cfg.month_mask[mo_r] && cfg.weekday_mask[wd_r];
  assign is_now   = (mo_r == now_mon_r) && (d_r == now_day_r);
  assign is_later = (mo_r > now_mon_r) || ((mo_r == now_mon_r) && (d_r > now_day_r));
  assign last_day = (d_r == cnm_pkg::month_last_day(mo_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cnm_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_min_r   <= now_min_nxt;
    now_hr_r    <= now_hr_nxt;
    now_day_r   <= now_day_nxt;
    now_mon_r   <= now_mon_nxt;
    idx_r       <= idx_nxt;
    fm_vld_r    <= fm_vld_nxt;
    lm_vld_r    <= lm_vld_nxt;
    fh_vld_r    <= fh_vld_nxt;
    lh_vld_r    <= lh_vld_nxt;
    hr_ok_r     <= hr_ok_nxt;
    fm_r        <= fm_nxt;
    lm_r        <= lm_nxt;
    lh_r        <= lh_nxt;
    mo_r        <= mo_nxt;
    d_r         <= d_nxt;
    wd_r        <= wd_nxt;
    res_found_r <= res_found_nxt;
    res_min_r   <= res_min_nxt;
    res_hr_r    <= res_hr_nxt;
    res_day_r   <= res_day_nxt;
    res_mon_r   <= res_mon_nxt;
    res_wd_r    <= res_wd_nxt;
    out_found_r <= out_found_nxt;
    out_min_r   <= out_min_nxt;
    out_hr_r    <= out_hr_nxt;
    out_day_r   <= out_day_nxt;
    out_mon_r   <= out_mon_nxt;
    out_wd_r    <= out_wd_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    now_min_nxt   = now_min_r;
    now_hr_nxt    = now_hr_r;
    now_day_nxt   = now_day_r;
    now_mon_nxt   = now_mon_r;
    idx_nxt       = idx_r;
    fm_vld_nxt    = fm_vld_r;
    lm_vld_nxt    = lm_vld_r;
    fh_vld_nxt    = fh_vld_r;
    lh_vld_nxt    = lh_vld_r;
    hr_ok_nxt     = hr_ok_r;
    fm_nxt        = fm_r;
    lm_nxt        = lm_r;
    lh_nxt        = lh_r;
    mo_nxt        = mo_r;
    d_nxt         = d_r;
    wd_nxt        = wd_r;
    res_found_nxt = res_found_r;
    res_min_nxt   = res_min_r;
    res_hr_nxt    = res_hr_r;
    res_day_nxt   = res_day_r;
    res_mon_nxt   = res_mon_r;
    res_wd_nxt    = res_wd_r;
    out_valid_nxt = out_valid_r;
    out_found_nxt = out_found_r;
    out_min_nxt   = out_min_r;
    out_hr_nxt    = out_hr_r;
    out_day_nxt   = out_day_r;
    out_mon_nxt   = out_mon_r;
    out_wd_nxt    = out_wd_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      cnm_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          now_min_nxt = in_ch.now_minute;
          now_hr_nxt  = in_ch.now_hour;
          now_day_nxt = in_ch.now_day;
          now_mon_nxt = in_ch.now_month;
          idx_nxt     = '0;
          fm_vld_nxt  = 1'b0;
          lm_vld_nxt  = 1'b0;
          fh_vld_nxt  = 1'b0;
          lh_vld_nxt  = 1'b0;
          hr_ok_nxt   = 1'b0;
          state_nxt   = cnm_pkg::ST_SCAN;
        end
      end

      cnm_pkg::ST_SCAN: begin
        if (mbit && !fm_vld_r) begin
          fm_vld_nxt = 1'b1;
          fm_nxt     = idx_r;
        end
        if (mbit && !lm_vld_r && (idx_r > now_min_r)) begin
          lm_vld_nxt = 1'b1;
          lm_nxt     = idx_r;
        end
        if (hbit) begin
          fh_vld_nxt = 1'b1;
        end
        if (hbit && !lh_vld_r && (idx_r > {1'b0, now_hr_r})) begin
          lh_vld_nxt = 1'b1;
          lh_nxt     = idx_r[4:0];
        end
        if (hbit && (idx_r == {1'b0, now_hr_r})) begin
          hr_ok_nxt = 1'b1;
        end
        idx_nxt = idx_r + 6'd1;
        if (idx_r == LAST_SCAN) begin
          mo_nxt = '0;
          d_nxt  = '0;
          wd_nxt = (cfg.first_weekday == 3'(cnm_pkg::DAYS_PER_WEEK)) ? 3'd0
                                                                      : cfg.first_weekday;
          // An empty minute or hour mask can never match.
          if (!(fm_vld_r || mbit) || !fh_vld_r) begin
            res_found_nxt = 1'b0;
            res_min_nxt   = '0;
            res_hr_nxt    = '0;
            res_day_nxt   = '0;
            res_mon_nxt   = '0;
            res_wd_nxt    = '0;
            state_nxt     = cnm_pkg::ST_DONE;
          end else begin
            state_nxt = cnm_pkg::ST_WALK;
          end
        end
      end

      cnm_pkg::ST_WALK: begin
        if (allowed && ((is_now && today_vld) || is_later)) begin
          res_found_nxt = 1'b1;
          res_min_nxt   = is_now ? today_min : fm_r;
          res_hr_nxt    = is_now ? today_hr : fh_r;
          res_day_nxt   = d_r;
          res_mon_nxt   = mo_r;
          res_wd_nxt    = wd_r;
          state_nxt     = cnm_pkg::ST_DONE;
        end else if (last_day && (mo_r == LAST_MONTH)) begin
          res_found_nxt = 1'b0;
          res_min_nxt   = '0;
          res_hr_nxt    = '0;
          res_day_nxt   = '0;
          res_mon_nxt   = '0;
          res_wd_nxt    = '0;
          state_nxt     = cnm_pkg::ST_DONE;
        end else begin
          if (last_day) begin
            mo_nxt = mo_r + 4'd1;
            d_nxt  = '0;
          end else begin
            d_nxt = d_r + 5'd1;
          end
          wd_nxt = (wd_r == LAST_WD) ? 3'd0 : wd_r + 3'd1;
        end
      end

      cnm_pkg::ST_DONE: begin
        // Hand over once the output register is free.
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_min_nxt   = res_min_r;
          out_hr_nxt    = res_hr_r;
          out_day_nxt   = res_day_r;
          out_mon_nxt   = res_mon_r;
          out_wd_nxt    = res_wd_r;
          state_nxt     = cnm_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = cnm_pkg::ST_IDLE;
      end
    endcase
  end

  // First allowed hour, kept in the scan as the hour register of that search.
  always_comb begin
    fh_nxt = fh_r;
    if (state_r == cnm_pkg::ST_SCAN && hbit && !fh_vld_r) begin
      fh_nxt = idx_r[4:0];
    end
  end

  always_ff @(posedge clk) begin
    fh_r <= fh_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/cnm_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// cnm_cfg_regs
// Mask and first-weekday registers, written over the configuration channel.
// ----------------------------------------------------------------------------
`default_nettype none

module cnm_cfg_regs (
  input  wire logic        clk,
  input  wire logic        rst_n,
  cnm_cfg_if.sink          cfg_ch,
  output cnm_pkg::cfg_t    cfg
);

  cnm_pkg::cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_ch.valid) begin
      case (cnm_pkg::reg_idx_t'(cfg_ch.index))
        cnm_pkg::REG_MINUTE_MASK:   cfg_r.minute_mask   <= cfg_ch.data[59:0];
        cnm_pkg::REG_HOUR_MASK:     cfg_r.hour_mask     <= cfg_ch.data[23:0];
        cnm_pkg::REG_DAY_MASK:      cfg_r.day_mask      <= cfg_ch.data[30:0];
        cnm_pkg::REG_MONTH_MASK:    cfg_r.month_mask    <= cfg_ch.data[11:0];
        cnm_pkg::REG_WEEKDAY_MASK:  cfg_r.weekday_mask  <= cfg_ch.data[6:0];
        cnm_pkg::REG_FIRST_WEEKDAY: cfg_r.first_weekday <= cfg_ch.data[2:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cnm_checker.sv =====
// ----------------------------------------------------------------------------
// cnm_checker
// Port-level checks on the next-match search, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cnm_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       found,
  input wire logic [5:0] next_minute,
  input wire logic [4:0] next_hour,
  input wire logic [4:0] next_day,
  input wire logic [3:0] next_month,
  input wire logic [2:0] next_weekday
);

  // A miss carries an all-zero time.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !found |-> next_minute == 6'd0 && next_hour == 5'd0 &&
                            next_day == 5'd0 && next_month == 4'd0 && next_weekday == 3'd0)
    else $error("miss result carries a nonzero time");

  // A hit names a real calendar time.
  a_hit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && found |-> next_minute < 6'd60 && next_hour < 5'd24 &&
                           next_month < 4'd12 && next_weekday < 3'd7)
    else $error("hit result out of calendar range");

  // One query at a time: the input closes right after an item is taken.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready while a query is in progress");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(found) && $stable(next_minute) &&
                                $stable(next_hour) && $stable(next_day) &&
                                $stable(next_month) && $stable(next_weekday))
    else $error("stalled result changed");

endmodule

bind cron_next_match_search cnm_checker u_cnm_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .found        (out_ch.found),
  .next_minute  (out_ch.next_minute),
  .next_hour    (out_ch.next_hour),
  .next_day     (out_ch.next_day),
  .next_month   (out_ch.next_month),
  .next_weekday (out_ch.next_weekday)
);

`default_nettype wire
